// ===== design/buddy_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int HANDLE_W = 16;
  localparam int OFFSET_W = 5;
  localparam int INDEX_W  = 5;
  localparam int SIZE_W   = 32;
  localparam int SHIFT_W  = 5;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_BAD_SIZE   = 2'd2,
    STAT_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    NODE_ABSENT = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_USED   = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_e;

  typedef enum logic [2:0] {
    K_ALLOC      = 3'd0,
    K_FREE       = 3'd1,
    K_QUERY      = 3'd2,
    K_NOP        = 3'd3,
    K_BAD_SIZE   = 3'd4,
    K_BAD_HANDLE = 3'd5
  } kind_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_SPLIT_P,
    S_SPLIT_L,
    S_SPLIT_R,
    S_MARK,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_CHK,
    S_M_SIB,
    S_M_PAR,
    S_Q_RD,
    S_Q_CHK,
    S_OUT
  } back_state_e;

  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
  } op_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_ctl_t;

endpackage

`default_nettype wire

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over a power-of-two pool of blocks
// ----------------------------------------------------------------------------
// sequence: query walks the tree level by level; free scans the nodes, then
//   merges level by level until the sibling is not free or the root is reached;
//   allocate scans the nodes from the target level upward, then splits down to it
// throughput: one item at a time through the node ram sequencer
// reset: a clearing pass over all 2*POOL_BLOCKS-1 nodes sets the tree, items stalled
`default_nettype none

module buddy_block_allocator #(
  parameter int POOL_BLOCKS = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bba_pkg::SHIFT_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [bba_pkg::SIZE_W-1:0]    size_bytes_i,
  input  wire logic [bba_pkg::HANDLE_W-1:0]  handle_in_i,
  input  wire logic [bba_pkg::INDEX_W-1:0]   block_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [bba_pkg::HANDLE_W-1:0]       handle_out_o,
  output logic [bba_pkg::OFFSET_W-1:0]       block_offset_o,
  output logic                               block_used_o
);

  localparam int LEVELS = $clog2(POOL_BLOCKS);
  localparam int DW = $clog2(LEVELS + 1);

  logic [bba_pkg::SHIFT_W-1:0] block_shift_q;
  bba_pkg::back_ctl_t          ctl;
  logic                        q_valid;
  bba_pkg::op_t                q_op;
  logic [DW-1:0]               q_tgt;
  logic [LEVELS-1:0]           q_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q <= bba_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      block_shift_q <= cfg_data_i;
    end
  end

  bba_front #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .size_bytes_i  (size_bytes_i),
    .handle_in_i   (handle_in_i),
    .block_index_i (block_index_i),
    .block_shift_i (block_shift_q),
    .ctl_i         (ctl),
    .q_valid_o     (q_valid),
    .q_op_o        (q_op),
    .q_tgt_o       (q_tgt),
    .q_idx_o       (q_idx)
  );

  bba_back #(
    .POOL_BLOCKS (POOL_BLOCKS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_op_i         (q_op),
    .q_tgt_i        (q_tgt),
    .q_idx_i        (q_idx),
    .ctl_o          (ctl),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .handle_out_o   (handle_out_o),
    .block_offset_o (block_offset_o),
    .block_used_o   (block_used_o)
  );

endmodule

`default_nettype wire

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 63,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bba_front.sv =====
// ----------------------------------------------------------------------------
// bba_front
// accepts items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module bba_front #(
  parameter int POOL_BLOCKS = 32,
  localparam int LEVELS = $clog2(POOL_BLOCKS),
  localparam int DW = $clog2(LEVELS + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     mode_i,
  input  wire logic [bba_pkg::SIZE_W-1:0]     size_bytes_i,
  input  wire logic [bba_pkg::HANDLE_W-1:0]   handle_in_i,
  input  wire logic [bba_pkg::INDEX_W-1:0]    block_index_i,
  input  wire logic [bba_pkg::SHIFT_W-1:0]    block_shift_i,
  input  wire bba_pkg::back_ctl_t             ctl_i,
  output logic                                q_valid_o,
  output bba_pkg::op_t                        q_op_o,
  output logic [DW-1:0]                       q_tgt_o,
  output logic [LEVELS-1:0]                   q_idx_o
);

  bba_pkg::op_t      op_q  [2];
  logic [DW-1:0]     tgt_q [2];
  logic [LEVELS-1:0] idx_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  bba_pkg::op_t      op_w;
  logic [DW-1:0]     tgt_w;
  logic [LEVELS-1:0] idx_w;
  logic              push;
  logic              pop;

  always_comb begin
    logic [32:0]                        round_add;
    logic [32:0]                        blocks;
    logic [DW-1:0]                      lg;
    logic [LEVELS+bba_pkg::INDEX_W-1:0] idx_ext;
    round_add = (33'd1 << block_shift_i) - 33'd1;
    blocks    = ({1'b0, size_bytes_i} + round_add) >> block_shift_i;
    lg        = '0;
    for (int l = LEVELS; l >= 0; l--) begin
      if ((33'd1 << l) >= blocks) begin
        lg = DW'(l);
      end
    end
    tgt_w       = DW'(LEVELS) - lg;
    idx_ext     = {{LEVELS{1'b0}}, block_index_i};
    idx_w       = idx_ext[LEVELS-1:0];
    op_w.handle = handle_in_i;
    case (mode_i)
      bba_pkg::MODE_ALLOC: begin
        if (size_bytes_i == '0 || blocks > 33'(POOL_BLOCKS)) begin
          op_w.kind = bba_pkg::K_BAD_SIZE;
        end else begin
          op_w.kind = bba_pkg::K_ALLOC;
        end
      end
      bba_pkg::MODE_FREE: begin
        if (handle_in_i == '0) begin
          op_w.kind = bba_pkg::K_BAD_HANDLE;
        end else begin
          op_w.kind = bba_pkg::K_FREE;
        end
      end
      bba_pkg::MODE_QUERY: begin
        if ({27'd0, block_index_i} >= 32'(POOL_BLOCKS)) begin
          op_w.kind = bba_pkg::K_NOP;
        end else begin
          op_w.kind = bba_pkg::K_QUERY;
        end
      end
      default: begin
        op_w.kind = bba_pkg::K_NOP;
      end
    endcase
  end

  assign in_stall_o = (count_q == 2'd2) || ctl_i.clearing;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctl_i.pop;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_op_o     = op_q[rd_ptr_q];
  assign q_tgt_o    = tgt_q[rd_ptr_q];
  assign q_idx_o    = idx_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_w;
      tgt_q[wr_ptr_q] <= tgt_w;
      idx_q[wr_ptr_q] <= idx_w;
    end
  end

endmodule

`default_nettype wire

// ===== design/bba_back.sv =====
// ----------------------------------------------------------------------------
// bba_back
// sequencer that walks the buddy tree and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module bba_back #(
  parameter int POOL_BLOCKS = 32,
  parameter int HANDLE_BITS = 16,
  localparam int LEVELS = $clog2(POOL_BLOCKS),
  localparam int DW = $clog2(LEVELS + 1),
  localparam int NODES = 2 * POOL_BLOCKS - 1,
  localparam int NW = LEVELS + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire bba_pkg::op_t                 q_op_i,
  input  wire logic [DW-1:0]                q_tgt_i,
  input  wire logic [LEVELS-1:0]            q_idx_i,
  output bba_pkg::back_ctl_t                ctl_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        status_o,
  output logic [bba_pkg::HANDLE_W-1:0]      handle_out_o,
  output logic [bba_pkg::OFFSET_W-1:0]      block_offset_o,
  output logic                              block_used_o
);

  bba_pkg::back_state_e state_q, state_d;
  logic [NW-1:0]              node_q, node_d;
  logic [DW-1:0]              d_q, d_d;
  logic [LEVELS-1:0]          i_q, i_d;
  logic [DW-1:0]              tgt_q, tgt_d;
  logic [LEVELS-1:0]          idx_q, idx_d;
  logic [bba_pkg::HANDLE_W-1:0] hin_q, hin_d;
  logic [HANDLE_BITS-1:0]     last_q, last_d;
  logic [NW-1:0]              clr_q, clr_d;
  logic [1:0]                 res_status_q, res_status_d;
  logic [bba_pkg::HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [bba_pkg::OFFSET_W-1:0] res_off_q, res_off_d;
  logic                       res_used_q, res_used_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_load;
  logic [1:0]                 status_q;
  logic [bba_pkg::HANDLE_W-1:0] handle_q;
  logic [bba_pkg::OFFSET_W-1:0] offset_q;
  logic                       used_q;

  logic                   node_we;
  logic [NW-1:0]          node_waddr;
  logic [1:0]             node_wdata;
  logic [NW-1:0]          node_raddr;
  logic [1:0]             node_rd;
  logic                   own_we;
  logic [HANDLE_BITS-1:0] own_rd;

  logic [NW-1:0]          one_nw;
  logic [NW-1:0]          lvl_first;
  logic [NW-1:0]          tgt_first;
  logic [NW-1:0]          prev_first;
  logic [NW:0]            two_n;
  logic [NW-1:0]          left_n;
  logic [NW-1:0]          right_n;
  logic [NW-1:0]          parent_n;
  logic [NW-1:0]          sib_n;
  logic [LEVELS-1:0]      off_w;
  logic [LEVELS+4:0]      off_ext;
  logic [HANDLE_BITS-1:0] next_h;
  logic [HANDLE_BITS+15:0] next_h_ext;
  logic [HANDLE_BITS+15:0] hin_ext;
  logic [HANDLE_BITS+15:0] own_ext;
  logic [LEVELS-1:0]      qsh;

  assign one_nw     = NW'(1);
  assign lvl_first  = (one_nw << d_q) - one_nw;
  assign tgt_first  = (one_nw << q_tgt_i) - one_nw;
  assign prev_first = (one_nw << (d_q - DW'(1))) - one_nw;
  assign two_n      = {node_q, 1'b0};
  assign left_n     = NW'(two_n + (NW+1)'(1));
  assign right_n    = NW'(two_n + (NW+1)'(2));
  assign parent_n   = (node_q - one_nw) >> 1;
  assign sib_n      = node_q[0] ? (node_q + one_nw) : (node_q - one_nw);
  assign off_w      = i_q << (DW'(LEVELS) - d_q);
  assign off_ext    = {5'd0, off_w};
  assign next_h     = last_q + HANDLE_BITS'(1);
  assign next_h_ext = {16'd0, next_h};
  assign hin_ext    = {{HANDLE_BITS{1'b0}}, hin_q};
  assign own_ext    = {16'd0, own_rd};
  assign qsh        = idx_q >> (DW'(LEVELS - 1) - d_q);
  assign node_raddr = (state_q == bba_pkg::S_M_RD) ? sib_n : node_q;

  bba_ram #(
    .WIDTH (2),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rd)
  );

  bba_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (POOL_BLOCKS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (off_w),
    .wdata_i (next_h),
    .raddr_i (off_w),
    .rdata_o (own_rd)
  );

  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    d_d          = d_q;
    i_d          = i_q;
    tgt_d        = tgt_q;
    idx_d        = idx_q;
    hin_d        = hin_q;
    last_d       = last_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_off_d    = res_off_q;
    res_used_d   = res_used_q;
    node_we      = 1'b0;
    node_waddr   = node_q;
    node_wdata   = bba_pkg::NODE_ABSENT;
    own_we       = 1'b0;
    out_load     = 1'b0;
    ctl_o.pop      = 1'b0;
    ctl_o.clearing = (state_q == bba_pkg::S_CLEAR);
    case (state_q)
      bba_pkg::S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = (clr_q == '0) ? bba_pkg::NODE_FREE : bba_pkg::NODE_ABSENT;
        clr_d      = clr_q + one_nw;
        if (clr_q == NW'(NODES - 1)) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        res_status_d = bba_pkg::STAT_OK;
        res_handle_d = '0;
        res_off_d    = '0;
        res_used_d   = 1'b0;
        node_d       = '0;
        d_d          = '0;
        i_d          = '0;
        tgt_d        = q_tgt_i;
        idx_d        = q_idx_i;
        hin_d        = q_op_i.handle;
        if (q_valid_i) begin
          ctl_o.pop = 1'b1;
          case (q_op_i.kind)
            bba_pkg::K_ALLOC: begin
              if (&last_q) begin
                res_status_d = bba_pkg::STAT_NO_SPACE;
                state_d      = bba_pkg::S_OUT;
              end else begin
                d_d     = q_tgt_i;
                node_d  = tgt_first;
                state_d = bba_pkg::S_A_RD;
              end
            end
            bba_pkg::K_FREE:       state_d = bba_pkg::S_F_RD;
            bba_pkg::K_QUERY:      state_d = bba_pkg::S_Q_RD;
            bba_pkg::K_BAD_SIZE: begin
              res_status_d = bba_pkg::STAT_BAD_SIZE;
              state_d      = bba_pkg::S_OUT;
            end
            bba_pkg::K_BAD_HANDLE: begin
              res_status_d = bba_pkg::STAT_BAD_HANDLE;
              state_d      = bba_pkg::S_OUT;
            end
            default:               state_d = bba_pkg::S_OUT;
          endcase
        end
      end
      bba_pkg::S_A_RD: state_d = bba_pkg::S_A_CHK;
      bba_pkg::S_A_CHK: begin
        if (node_rd == bba_pkg::NODE_FREE) begin
          state_d = (d_q == tgt_q) ? bba_pkg::S_MARK : bba_pkg::S_SPLIT_P;
        end else if ({1'b0, i_q} == lvl_first) begin
          if (d_q == '0) begin
            res_status_d = bba_pkg::STAT_NO_SPACE;
            state_d      = bba_pkg::S_OUT;
          end else begin
            d_d     = d_q - DW'(1);
            i_d     = '0;
            node_d  = prev_first;
            state_d = bba_pkg::S_A_RD;
          end
        end else begin
          i_d     = i_q + LEVELS'(1);
          node_d  = node_q + one_nw;
          state_d = bba_pkg::S_A_RD;
        end
      end
      bba_pkg::S_SPLIT_P: begin
        node_we    = 1'b1;
        node_wdata = bba_pkg::NODE_SPLIT;
        state_d    = bba_pkg::S_SPLIT_L;
      end
      bba_pkg::S_SPLIT_L: begin
        node_we    = 1'b1;
        node_waddr = left_n;
        node_wdata = bba_pkg::NODE_FREE;
        state_d    = bba_pkg::S_SPLIT_R;
      end
      bba_pkg::S_SPLIT_R: begin
        node_we    = 1'b1;
        node_waddr = right_n;
        node_wdata = bba_pkg::NODE_FREE;
        node_d     = left_n;
        d_d        = d_q + DW'(1);
        i_d        = i_q << 1;
        state_d    = (d_q + DW'(1) == tgt_q) ? bba_pkg::S_MARK : bba_pkg::S_SPLIT_P;
      end
      bba_pkg::S_MARK: begin
        node_we      = 1'b1;
        node_wdata   = bba_pkg::NODE_USED;
        own_we       = 1'b1;
        last_d       = next_h;
        res_handle_d = next_h_ext[15:0];
        res_off_d    = off_ext[4:0];
        state_d      = bba_pkg::S_OUT;
      end
      bba_pkg::S_F_RD: state_d = bba_pkg::S_F_CHK;
      bba_pkg::S_F_CHK: begin
        if (node_rd == bba_pkg::NODE_USED && own_ext == hin_ext) begin
          node_we    = 1'b1;
          node_wdata = bba_pkg::NODE_FREE;
          state_d    = bba_pkg::S_M_RD;
        end else if (node_q == NW'(NODES - 1)) begin
          res_status_d = bba_pkg::STAT_BAD_HANDLE;
          state_d      = bba_pkg::S_OUT;
        end else begin
          node_d  = node_q + one_nw;
          state_d = bba_pkg::S_F_RD;
          if ({1'b0, i_q} == lvl_first) begin
            d_d = d_q + DW'(1);
            i_d = '0;
          end else begin
            i_d = i_q + LEVELS'(1);
          end
        end
      end
      bba_pkg::S_M_RD: begin
        state_d = (node_q == '0) ? bba_pkg::S_OUT : bba_pkg::S_M_CHK;
      end
      bba_pkg::S_M_CHK: begin
        if (node_rd == bba_pkg::NODE_FREE) begin
          node_we = 1'b1;
          state_d = bba_pkg::S_M_SIB;
        end else begin
          state_d = bba_pkg::S_OUT;
        end
      end
      bba_pkg::S_M_SIB: begin
        node_we    = 1'b1;
        node_waddr = sib_n;
        state_d    = bba_pkg::S_M_PAR;
      end
      bba_pkg::S_M_PAR: begin
        node_we    = 1'b1;
        node_waddr = parent_n;
        node_wdata = bba_pkg::NODE_FREE;
        node_d     = parent_n;
        state_d    = bba_pkg::S_M_RD;
      end
      bba_pkg::S_Q_RD: state_d = bba_pkg::S_Q_CHK;
      bba_pkg::S_Q_CHK: begin
        if (node_rd == bba_pkg::NODE_SPLIT && d_q < DW'(LEVELS)) begin
          node_d  = qsh[0] ? right_n : left_n;
          d_d     = d_q + DW'(1);
          state_d = bba_pkg::S_Q_RD;
        end else begin
          res_used_d = (node_rd == bba_pkg::NODE_USED);
          state_d    = bba_pkg::S_OUT;
        end
      end
      bba_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = bba_pkg::S_IDLE;
        end
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
    out_valid_d = (out_valid_q && out_stall_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::S_CLEAR;
      clr_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    d_q          <= d_d;
    i_q          <= i_d;
    tgt_q        <= tgt_d;
    idx_q        <= idx_d;
    hin_q        <= hin_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_off_q    <= res_off_d;
    res_used_q   <= res_used_d;
    if (out_load) begin
      status_q <= res_status_q;
      handle_q <= res_handle_q;
      offset_q <= res_off_q;
      used_q   <= res_used_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign handle_out_o   = handle_q;
  assign block_offset_o = offset_q;
  assign block_used_o   = used_q;

endmodule

`default_nettype wire

// ===== design/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// port level checks of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_block_allocator_macros.svh"

module bba_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [1:0]                   status_o,
  input wire logic [bba_pkg::HANDLE_W-1:0] handle_out_o,
  input wire logic [bba_pkg::OFFSET_W-1:0] block_offset_o,
  input wire logic                         block_used_o
);

  `BBA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(handle_out_o), "stalled item changed")
  `BBA_ASSERT_IMP(a_fail_clean, clk_i, rst_ni, out_valid_o && status_o != bba_pkg::STAT_OK, handle_out_o == '0 && block_offset_o == '0 && !block_used_o, "failed item carries data")
  `BBA_ASSERT_IMP(a_used_only_query, clk_i, rst_ni, out_valid_o && block_used_o, status_o == bba_pkg::STAT_OK && handle_out_o == '0, "used flag on a non-query item")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire

// ===== bench/tb_buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// self-checking bench: directed table, then random alloc/free/query traffic
// checked against an in-bench buddy tree, under several block sizes and
// random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_buddy_block_allocator;

  localparam int POOL  = 32;
  localparam int LEVELS = 5;
  localparam int NODES = 2 * POOL - 1;
  localparam int WATCH_LIMIT = 6000;

  typedef struct packed {
    bba_pkg::mode_e               mode;
    logic [bba_pkg::SIZE_W-1:0]   size;
    logic [bba_pkg::HANDLE_W-1:0] handle;
    logic [bba_pkg::INDEX_W-1:0]  idx;
  } req_t;

  typedef struct packed {
    bba_pkg::status_e             status;
    logic [bba_pkg::HANDLE_W-1:0] handle;
    logic [bba_pkg::OFFSET_W-1:0] offset;
    logic                         used;
  } resp_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    resp_t resp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bba_pkg::SHIFT_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic [bba_pkg::SIZE_W-1:0] size_bytes_i = '0;
  logic [bba_pkg::HANDLE_W-1:0] handle_in_i = '0;
  logic [bba_pkg::INDEX_W-1:0] block_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [bba_pkg::HANDLE_W-1:0] handle_out_o;
  logic [bba_pkg::OFFSET_W-1:0] block_offset_o;
  logic block_used_o;

  buddy_block_allocator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .mode_i, .size_bytes_i, .handle_in_i, .block_index_i, .out_valid_o,
    .out_stall_i, .status_o, .handle_out_o, .block_offset_o, .block_used_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // buddy tree mirror
  bba_pkg::node_e               tree_st [NODES];
  logic [bba_pkg::HANDLE_W-1:0] owner [POOL];
  logic [bba_pkg::HANDLE_W-1:0] last_handle;
  logic [bba_pkg::SHIFT_W-1:0]  blk_shift;

  resp_t expected_q[$];
  logic [bba_pkg::HANDLE_W-1:0] live_handles[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_arm = 1'b0;
  bit hold_taken = 1'b0;
  int quiet_cycles = 0;

  function automatic int depth_of(int node);
    int d;
    d = 0;
    while ((1 << (d + 1)) - 1 <= node) d++;
    return d;
  endfunction

  function automatic int offset_of(int node, int d);
    return (node - ((1 << d) - 1)) * (POOL >> d);
  endfunction

  task automatic buddy_step(input req_t r, output resp_t o);
    longint unsigned blocks, p;
    int lg, target, d, node, i, lo, par, sib, off;
    bit found;
    o = '0;
    found = 0;
    node = 0;
    case (r.mode)
      bba_pkg::MODE_ALLOC: begin
        blocks = ({32'd0, r.size} + (64'd1 << blk_shift) - 64'd1) >> blk_shift;
        if (r.size == 0 || blocks > POOL) begin
          o.status = bba_pkg::STAT_BAD_SIZE;
        end else if (last_handle == '1) begin
          o.status = bba_pkg::STAT_NO_SPACE;
        end else begin
          p = 1;
          lg = 0;
          while (p < blocks) begin
            p = p << 1;
            lg++;
          end
          target = LEVELS - lg;
          for (d = target; d >= 0 && !found; d--) begin
            lo = (1 << d) - 1;
            for (i = 0; i < (1 << d) && !found; i++) begin
              if (tree_st[lo + i] == bba_pkg::NODE_FREE) begin
                node = lo + i;
                found = 1;
              end
            end
            if (found) begin
              while (d < target) begin
                tree_st[node] = bba_pkg::NODE_SPLIT;
                tree_st[2 * node + 1] = bba_pkg::NODE_FREE;
                tree_st[2 * node + 2] = bba_pkg::NODE_FREE;
                node = 2 * node + 1;
                d++;
              end
            end
          end
          if (!found) begin
            o.status = bba_pkg::STAT_NO_SPACE;
          end else begin
            last_handle++;
            tree_st[node] = bba_pkg::NODE_USED;
            off = offset_of(node, target);
            owner[off] = last_handle;
            o.status = bba_pkg::STAT_OK;
            o.handle = last_handle;
            o.offset = off[bba_pkg::OFFSET_W-1:0];
            live_handles.push_back(last_handle);
          end
        end
      end
      bba_pkg::MODE_FREE: begin
        if (r.handle != 0) begin
          for (i = 0; i < NODES && !found; i++) begin
            if (tree_st[i] == bba_pkg::NODE_USED &&
                owner[offset_of(i, depth_of(i))] == r.handle) begin
              node = i;
              found = 1;
            end
          end
        end
        if (!found) begin
          o.status = bba_pkg::STAT_BAD_HANDLE;
        end else begin
          o.status = bba_pkg::STAT_OK;
          tree_st[node] = bba_pkg::NODE_FREE;
          while (node != 0) begin
            par = (node - 1) / 2;
            sib = (node & 1) ? node + 1 : node - 1;
            if (tree_st[sib] != bba_pkg::NODE_FREE) break;
            tree_st[node] = bba_pkg::NODE_ABSENT;
            tree_st[sib] = bba_pkg::NODE_ABSENT;
            tree_st[par] = bba_pkg::NODE_FREE;
            node = par;
          end
          for (i = 0; i < live_handles.size(); i++) begin
            if (live_handles[i] == r.handle) begin
              live_handles.delete(i);
              break;
            end
          end
        end
      end
      bba_pkg::MODE_QUERY: begin
        o.status = bba_pkg::STAT_OK;
        d = 0;
        while (tree_st[node] == bba_pkg::NODE_SPLIT && d < LEVELS) begin
          node = 2 * node + 1 + ((r.idx >> (LEVELS - d - 1)) & 1);
          d++;
        end
        o.used = (tree_st[node] == bba_pkg::NODE_USED);
      end
      default: o.status = bba_pkg::STAT_OK;
    endcase
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(input req_t r, input logic typed, input resp_t typed_resp);
    resp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= r.mode;
    size_bytes_i  <= r.size;
    handle_in_i   <= r.handle;
    block_index_i <= r.idx;
    do @(posedge clk_i); while (in_stall_o);
    buddy_step(r, pred);
    expected_q.push_back(typed ? typed_resp : pred);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_shift(input logic [bba_pkg::SHIFT_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blk_shift = v;
  endtask

  function automatic req_t random_req();
    req_t r;
    int pick, blocks;
    r.size   = $urandom;
    r.handle = bba_pkg::HANDLE_W'($urandom);
    r.idx    = bba_pkg::INDEX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.mode = bba_pkg::MODE_ALLOC;
      if ($urandom_range(9) != 0) begin
        blocks = ($urandom_range(3) == 0) ? $urandom_range(1, POOL) : $urandom_range(1, 4);
        r.size = ((blocks - 1) << blk_shift) + $urandom_range(1, 1 << blk_shift);
      end else if ($urandom_range(1) == 0) begin
        r.size = (POOL << blk_shift) + $urandom_range(1, 1 << blk_shift);
      end
    end else if (pick < 80) begin
      r.mode = bba_pkg::MODE_FREE;
      if (live_handles.size() != 0 && $urandom_range(9) != 0)
        r.handle = live_handles[$urandom_range(live_handles.size() - 1)];
      else if ($urandom_range(1) == 0)
        r.handle = bba_pkg::HANDLE_W'($urandom_range(last_handle));
    end else if (pick < 95) begin
      r.mode = bba_pkg::MODE_QUERY;
    end else begin
      r.mode = bba_pkg::MODE_NONE;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected item status", status_o, -1);
      end else begin
        resp_t e;
        e = expected_q.pop_front();
        if (status_o !== e.status) report("status", status_o, e.status);
        if (handle_out_o !== e.handle) report("handle_out", handle_out_o, e.handle);
        if (block_offset_o !== e.offset) report("block_offset", block_offset_o, e.offset);
        if (block_used_o !== e.used) report("block_used", block_used_o, e.used);
      end
    end
    if (hold_arm && !hold_taken) begin
      out_stall_i <= 1'b1;
      hold_left <= 400;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  row_t table_rows[$];

  function automatic row_t mk(bba_pkg::mode_e m, logic [31:0] s, logic [15:0] h,
                              logic [4:0] x, logic t, bba_pkg::status_e st,
                              logic [15:0] ho, logic [4:0] off, logic u);
    row_t w;
    w.req = '{mode: m, size: s, handle: h, idx: x};
    w.typed = t;
    w.resp = '{status: st, handle: ho, offset: off, used: u};
    return w;
  endfunction

  initial begin
    resp_t none;
    req_t r;
    none = '0;
    for (int i = 0; i < NODES; i++) tree_st[i] = bba_pkg::NODE_ABSENT;
    tree_st[0] = bba_pkg::NODE_FREE;
    for (int i = 0; i < POOL; i++) owner[i] = '0;
    last_handle = '0;
    blk_shift = bba_pkg::SHIFT_RESET;

    table_rows.push_back(mk(bba_pkg::MODE_QUERY, 0, 0, 0, 1, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_NONE, '1, '1, '1, 1, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 0, 0, 0, 1, bba_pkg::STAT_BAD_SIZE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, '1, 0, 0, 1, bba_pkg::STAT_BAD_SIZE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 32 * 4096 + 1, 0, 0, 1,
                            bba_pkg::STAT_BAD_SIZE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 0, 0, 1, bba_pkg::STAT_BAD_HANDLE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 5, 0, 1, bba_pkg::STAT_BAD_HANDLE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 1, 0, 0, 1, bba_pkg::STAT_OK, 1, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 32 * 4096, 0, 0, 1,
                            bba_pkg::STAT_NO_SPACE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 4097, 0, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 3 * 4096, 0, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 16 * 4096, 0, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_QUERY, 0, 0, 0, 1, bba_pkg::STAT_OK, 0, 0, 1));
    table_rows.push_back(mk(bba_pkg::MODE_QUERY, 0, 0, 31, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_QUERY, 0, 0, 9, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 1, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 1, 0, 1, bba_pkg::STAT_BAD_HANDLE, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 3, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 2, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 4, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_ALLOC, 32 * 4096, 0, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_QUERY, 0, 0, 16, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, 5, 0, 0, bba_pkg::STAT_OK, 0, 0, 0));
    table_rows.push_back(mk(bba_pkg::MODE_FREE, 0, '1, 0, 1, bba_pkg::STAT_BAD_HANDLE, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_shift(bba_pkg::SHIFT_RESET);

    send_idle_pct = 31;
    recv_idle_pct = 79;
    foreach (table_rows[i])
      send_item(table_rows[i].req, table_rows[i].typed, table_rows[i].resp);
    drain();

    write_shift(5'd0);
    for (int i = 0; i < 600; i++) send_item(random_req(), 1'b0, none);
    drain();

    send_idle_pct = 79;
    recv_idle_pct = 31;
    write_shift(5'd20);
    for (int i = 0; i < 600; i++) send_item(random_req(), 1'b0, none);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_shift(bba_pkg::SHIFT_W'($urandom_range(1, 19)));
    for (int i = 0; i < 300; i++) begin
      if (i == 50) hold_arm = 1'b1;
      send_item(random_req(), 1'b0, none);
    end
    drain();
    write_shift(bba_pkg::SHIFT_W'($urandom_range(1, 19)));
    for (int i = 0; i < 330; i++) send_item(random_req(), 1'b0, none);
    drain();
    repeat (100) @(posedge clk_i);

    $display("covered %0d items and %0d results over block shifts 0, 12, 20 and two random",
             items_sent, results_seen);
    $display("with sender and receiver idling, a long output hold-off and %0d mismatches",
             errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
